// File: sv/bmcs_pkg.sv
// Shared types and constants of the single-button menu and clock setter.
// No dependencies; every other file takes names from here by scope.
package bmcs_pkg;

  localparam logic [15:0] DEBOUNCE_RST = 16'd100;
  localparam logic [15:0] HOLD_RST     = 16'd1500;
  localparam logic [15:0] TIMEOUT_RST  = 16'd5000;

  localparam logic [5:0] HOURS_DAY  = 6'd24;
  localparam logic [5:0] HOURS_HALF = 6'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [6:0] MINS_HOUR  = 7'd60;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  typedef enum logic [1:0] {
    OP_POLL    = 2'd0,
    OP_REFRESH = 2'd1,
    OP_LOAD    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_HOLD     = 2'd1,
    CFG_TIMEOUT  = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_HOLD     = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_HOUR   = 3'd1,
    ST_MINUTE = 3'd2,
    ST_AMPM   = 3'd3,
    ST_MODE   = 3'd4
  } stage_t;

  typedef enum logic [1:0] {
    SCR_TRIP1 = 2'd0,
    SCR_TRIP2 = 2'd1,
    SCR_RANGE = 2'd2
  } screen_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
    logic [15:0] edit_timeout_ms;
  } cfg_t;

  typedef struct packed {
    phase_t      button_phase;
    logic [31:0] press_start_ms;
    logic        press_pending;
    stage_t      edit_stage;
    logic [31:0] last_action_ms;
    logic        skip_am_pm;
    logic        format_24;
    logic        morning;
    logic        metric_units;
    screen_t     screen_sel;
    logic [4:0]  held_hour;
    logic [5:0]  held_minute;
    logic        lamp;
  } state_t;

  typedef struct packed {
    logic clear_trip_one;
    logic clear_trip_two;
    logic clock_write;
  } pulse_t;

endpackage

// File: sv/button_menu_clock_setter_top.sv
// Top level of the single-button menu and clock setter.
// Depends on bmcs_pkg and bmcs_step.
//
// Each accepted item (button poll, refresh check, time load or no-op) yields
// exactly one result item that shows the menu state after that item, plus
// one-item pulses for trip clears and clock writes. An accepted item waits in
// the input register until the result register is free or being drained,
// then passes through the step logic into the result register, where the
// menu state is updated too, and its result is shown from there until taken.
// One item is accepted every cycle while the result side keeps taking items;
// the rate is set by the single step stage and its state feedback. The three
// timing registers (debounce, hold, edit timeout, all in milliseconds) are
// written through the cfg channel, which is always ready; an index beyond
// the list is dropped. Timestamps wrap modulo 2^32.
module button_menu_clock_setter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_now_ms,
  input  logic        in_pin_low,
  input  logic        in_press_edge,
  input  logic [4:0]  in_new_hour,
  input  logic [5:0]  in_new_minute,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_trip_screen,
  output logic [2:0]  out_edit_state,
  output logic        out_mode_24,
  output logic        out_is_am,
  output logic        out_unit_km,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic        out_led_on,
  output logic        out_clear_trip_one,
  output logic        out_clear_trip_two,
  output logic        out_clock_write
);

  bmcs_pkg::cfg_t   cfg_r;
  bmcs_pkg::state_t st_r;
  bmcs_pkg::state_t st_nxt;
  bmcs_pkg::pulse_t pulse_nxt;
  bmcs_pkg::pulse_t pulse_r;

  logic             s1_v_r;
  bmcs_pkg::op_t    s1_op_r;
  logic [31:0]      s1_now_r;
  logic             s1_pin_r;
  logic             s1_edge_r;
  logic [4:0]       s1_hour_r;
  logic [5:0]       s1_min_r;
  logic             out_v_r;

  logic advance;
  logic s1_fire;
  logic in_fire;

  // Move the input register forward whenever the result register is free
  // or being drained in this cycle.
  assign advance   = !out_v_r || out_ready;
  assign s1_fire   = s1_v_r && advance;
  assign in_ready  = !s1_v_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= bmcs_pkg::DEBOUNCE_RST;
      cfg_r.hold_ms         <= bmcs_pkg::HOLD_RST;
      cfg_r.edit_timeout_ms <= bmcs_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (bmcs_pkg::cfg_idx_t'(cfg_index))
        bmcs_pkg::CFG_DEBOUNCE: cfg_r.debounce_ms     <= cfg_data;
        bmcs_pkg::CFG_HOLD:     cfg_r.hold_ms         <= cfg_data;
        bmcs_pkg::CFG_TIMEOUT:  cfg_r.edit_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: valid is control, payload loads on accept only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= bmcs_pkg::op_t'(in_op);
      s1_now_r  <= in_now_ms;
      s1_pin_r  <= in_pin_low;
      s1_edge_r <= in_press_edge;
      s1_hour_r <= in_new_hour;
      s1_min_r  <= in_new_minute;
    end
  end

  bmcs_step u_step (
    .op         (s1_op_r),
    .now_ms     (s1_now_r),
    .pin_low    (s1_pin_r),
    .press_edge (s1_edge_r),
    .new_hour   (s1_hour_r),
    .new_minute (s1_min_r),
    .cfg        (cfg_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .pulse      (pulse_nxt)
  );

  // Menu state: advance once per item as it leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{button_phase: bmcs_pkg::PH_IDLE, edit_stage: bmcs_pkg::ST_NONE,
                screen_sel: bmcs_pkg::SCR_TRIP1, default: '0};
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register: holds the snapshot until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pulse_r <= pulse_nxt;
    end
  end

  // State register already holds the post-item values, so the result reads
  // it directly; it only changes together with the result register.
  assign out_valid          = out_v_r;
  assign out_trip_screen    = st_r.screen_sel;
  assign out_edit_state     = st_r.edit_stage;
  assign out_mode_24        = st_r.format_24;
  assign out_is_am          = st_r.morning;
  assign out_unit_km        = st_r.metric_units;
  assign out_hour_out       = st_r.held_hour;
  assign out_minute_out     = st_r.held_minute;
  assign out_led_on         = st_r.lamp;
  assign out_clear_trip_one = pulse_r.clear_trip_one;
  assign out_clear_trip_two = pulse_r.clear_trip_two;
  assign out_clock_write    = pulse_r.clock_write;

  // A trip clear goes to one trip only
  a_one_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_clear_trip_one && out_clear_trip_two))
    else $error("both trip clears raised");

  // Clock writes come only from edits on the range screen
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clock_write) |-> (out_trip_screen == bmcs_pkg::SCR_RANGE))
    else $error("clock write off the range screen");

  // Only button polls touch the lamp
  a_lamp_poll: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_op_r != bmcs_pkg::OP_POLL)) |=> $stable(st_r.lamp))
    else $error("lamp changed outside a poll");

  // Back pressure only when both registers are full and the result is stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_v_r && !out_ready))
    else $error("input stalled without cause");

  // State holds while no item passes the step stage
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(st_r))
    else $error("menu state changed without an item");

endmodule

// File: sv/bmcs_step.sv
// Next-state logic for one item: button debounce, edit actions, refresh
// timeout and time load. Combinational; uses bmcs_pkg types.
module bmcs_step (
  input  bmcs_pkg::op_t    op,
  input  logic [31:0]      now_ms,
  input  logic             pin_low,
  input  logic             press_edge,
  input  logic [4:0]       new_hour,
  input  logic [5:0]       new_minute,
  input  bmcs_pkg::cfg_t   cfg,
  input  bmcs_pkg::state_t st,
  output bmcs_pkg::state_t st_nxt,
  output bmcs_pkg::pulse_t pulse
);

  logic [31:0] since_press;
  logic [31:0] since_action;
  logic        debounce_done;
  logic        hold_done;
  logic        timeout_done;
  logic        no_edit;
  logic [5:0]  hour_inc;
  logic [5:0]  hour_wide;
  logic [5:0]  hour_24;
  logic [6:0]  minute_inc;
  logic [4:0]  load_hour;
  logic [5:0]  load_minute;

  assign since_press   = now_ms - st.press_start_ms;
  assign since_action  = now_ms - st.last_action_ms;
  assign debounce_done = since_press > {16'd0, cfg.debounce_ms};
  assign hold_done     = since_press > {16'd0, cfg.hold_ms};
  assign timeout_done  = since_action > {16'd0, cfg.edit_timeout_ms};
  assign no_edit       = (st.edit_stage == bmcs_pkg::ST_NONE) ||
                         (st.edit_stage > bmcs_pkg::ST_MODE);

  assign hour_wide  = {1'b0, st.held_hour};
  assign hour_inc   = hour_wide + 6'd1;
  assign minute_inc = {1'b0, st.held_minute} + 7'd1;
  assign load_hour   = (new_hour > bmcs_pkg::HOUR_MAX) ? bmcs_pkg::HOUR_MAX : new_hour;
  assign load_minute = (new_minute > bmcs_pkg::MINUTE_MAX) ? bmcs_pkg::MINUTE_MAX
                                                          : new_minute;

  // 12h to 24h conversion when the am/pm stage is left
  always_comb begin
    logic [5:0] r;
    if (st.morning) begin
      r = (hour_wide == bmcs_pkg::HOURS_HALF) ? 6'd0 : hour_wide;
    end else begin
      r = (hour_wide == bmcs_pkg::HOURS_HALF) ? bmcs_pkg::HOURS_HALF
                                              : hour_wide + bmcs_pkg::HOURS_HALF;
    end
    hour_24 = (r >= bmcs_pkg::HOURS_DAY) ? r - bmcs_pkg::HOURS_DAY : r;
  end

  always_comb begin
    st_nxt = st;
    pulse  = '0;
    case (op)
      bmcs_pkg::OP_POLL: begin
        if (press_edge || st.press_pending) begin
          st_nxt.press_pending = 1'b1;
          if (pin_low) begin
            case (st.button_phase)
              bmcs_pkg::PH_IDLE: begin
                st_nxt.button_phase   = bmcs_pkg::PH_DEBOUNCE;
                st_nxt.press_start_ms = now_ms;
              end
              bmcs_pkg::PH_DEBOUNCE: begin
                if (debounce_done) begin
                  st_nxt.button_phase = bmcs_pkg::PH_PRESSED;
                  st_nxt.lamp         = 1'b1;
                  if (st.screen_sel == bmcs_pkg::SCR_RANGE) begin
                    case (st.edit_stage)
                      bmcs_pkg::ST_MODE: begin
                        st_nxt.format_24      = ~st.format_24;
                        st_nxt.skip_am_pm     = ~st.format_24;
                        st_nxt.last_action_ms = now_ms;
                      end
                      bmcs_pkg::ST_AMPM: begin
                        st_nxt.morning        = ~st.morning;
                        pulse.clock_write     = 1'b1;
                        st_nxt.last_action_ms = now_ms;
                      end
                      bmcs_pkg::ST_HOUR: begin
                        if (st.format_24) begin
                          st_nxt.held_hour = (hour_inc >= bmcs_pkg::HOURS_DAY) ?
                              5'(hour_inc - bmcs_pkg::HOURS_DAY) : hour_inc[4:0];
                        end else begin
                          st_nxt.held_hour = (hour_inc > bmcs_pkg::HOURS_HALF) ?
                              5'd1 : hour_inc[4:0];
                        end
                        pulse.clock_write     = 1'b1;
                        st_nxt.last_action_ms = now_ms;
                      end
                      bmcs_pkg::ST_MINUTE: begin
                        st_nxt.held_minute = (minute_inc >= bmcs_pkg::MINS_HOUR) ?
                            6'(minute_inc - bmcs_pkg::MINS_HOUR) : minute_inc[5:0];
                        pulse.clock_write     = 1'b1;
                        st_nxt.last_action_ms = now_ms;
                      end
                      default: ;
                    endcase
                  end
                end
              end
              bmcs_pkg::PH_PRESSED: begin
                if (hold_done) begin
                  st_nxt.button_phase = bmcs_pkg::PH_HOLD;
                  case (st.screen_sel)
                    bmcs_pkg::SCR_RANGE: begin
                      if (no_edit) st_nxt.edit_stage = bmcs_pkg::ST_MODE;
                      st_nxt.last_action_ms = now_ms;
                    end
                    bmcs_pkg::SCR_TRIP1: pulse.clear_trip_one = 1'b1;
                    bmcs_pkg::SCR_TRIP2: pulse.clear_trip_two = 1'b1;
                    default: ;
                  endcase
                end
              end
              default: ;
            endcase
          end else begin
            // release: only a short press acts
            if (st.button_phase == bmcs_pkg::PH_PRESSED) begin
              case (st.screen_sel)
                bmcs_pkg::SCR_RANGE: begin
                  if (no_edit) begin
                    st_nxt.screen_sel   = bmcs_pkg::SCR_TRIP1;
                    st_nxt.metric_units = ~st.metric_units;
                  end
                end
                bmcs_pkg::SCR_TRIP1: st_nxt.screen_sel = bmcs_pkg::SCR_TRIP2;
                bmcs_pkg::SCR_TRIP2: st_nxt.screen_sel = bmcs_pkg::SCR_RANGE;
                default: ;
              endcase
            end
            st_nxt.lamp          = 1'b0;
            st_nxt.button_phase  = bmcs_pkg::PH_IDLE;
            st_nxt.press_pending = 1'b0;
          end
        end
      end
      bmcs_pkg::OP_REFRESH: begin
        if (timeout_done) begin
          case (st.edit_stage)
            bmcs_pkg::ST_MODE: begin
              st_nxt.edit_stage = st.skip_am_pm ? bmcs_pkg::ST_HOUR : bmcs_pkg::ST_AMPM;
              st_nxt.last_action_ms = now_ms;
            end
            bmcs_pkg::ST_AMPM: begin
              st_nxt.edit_stage     = bmcs_pkg::ST_HOUR;
              st_nxt.last_action_ms = now_ms;
              if (st.format_24) begin
                st_nxt.held_hour = hour_24[4:0];
              end else if (st.held_hour == 5'd0) begin
                st_nxt.held_hour = 5'(bmcs_pkg::HOURS_HALF);
                st_nxt.morning   = 1'b1;
              end else if (hour_wide == bmcs_pkg::HOURS_HALF) begin
                st_nxt.morning = 1'b0;
              end else if (hour_wide > bmcs_pkg::HOURS_HALF) begin
                st_nxt.held_hour = 5'(hour_wide - bmcs_pkg::HOURS_HALF);
                st_nxt.morning   = 1'b0;
              end else begin
                st_nxt.morning = 1'b1;
              end
            end
            bmcs_pkg::ST_HOUR: begin
              st_nxt.edit_stage     = bmcs_pkg::ST_MINUTE;
              st_nxt.last_action_ms = now_ms;
            end
            bmcs_pkg::ST_MINUTE: begin
              st_nxt.edit_stage = bmcs_pkg::ST_NONE;
              st_nxt.screen_sel = bmcs_pkg::SCR_TRIP1;
            end
            default: ;
          endcase
        end
      end
      bmcs_pkg::OP_LOAD: begin
        if ((load_hour != st.held_hour) && (hour_wide == bmcs_pkg::HOURS_HALF))
          st_nxt.morning = ~st.morning;
        st_nxt.held_minute = load_minute;
        if (!st.format_24 && ({1'b0, load_hour} > bmcs_pkg::HOURS_HALF)) begin
          st_nxt.held_hour = 5'({1'b0, load_hour} - bmcs_pkg::HOURS_HALF);
        end else begin
          st_nxt.held_hour = load_hour;
        end
      end
      default: ;
    endcase
  end

endmodule
